[rtl/crsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsp_pkg: shared widths and types for covariance rotation/scale propagation
// Fixed-point widths of the datapath and the quaternion product bundle.
// ----------------------------------------------------------------------------
package crsp_pkg;

  localparam int QW    = 32;   // quaternion part, Q1.30
  localparam int SW    = 32;   // scale, unsigned Q16.16
  localparam int CW    = 48;   // covariance entry, Q16.32
  localparam int PRW   = 64;   // quaternion product, Q.60
  localparam int RW    = 32;   // rotation entry, Q.30 clamped to [-1, 1]
  localparam int NCOV  = 6;    // distinct entries of a symmetric 3x3

  // The nine products of quaternion parts, each exact in Q.60.
  typedef struct packed {
    logic signed [PRW-1:0] xx;
    logic signed [PRW-1:0] yy;
    logic signed [PRW-1:0] zz;
    logic signed [PRW-1:0] xy;
    logic signed [PRW-1:0] xz;
    logic signed [PRW-1:0] yz;
    logic signed [PRW-1:0] wx;
    logic signed [PRW-1:0] wy;
    logic signed [PRW-1:0] wz;
  } quat_prod_t;

endpackage

[rtl/crsp_quat_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsp_quat_rot: quaternion products to rotation matrix
// Forms each entry in Q.60, rounds half up to Q.30 and clamps to [-1, 1].
// ----------------------------------------------------------------------------
module crsp_quat_rot
  import crsp_pkg::*;
(
  input  quat_prod_t            prod_i,
  output logic signed [RW-1:0]  rmat_o [3][3]
);

  localparam logic signed [37:0] OneQ30 = 38'sd1073741824;

  function automatic logic signed [RW-1:0] rot_entry(input logic diag,
                                                      input logic signed [PRW-1:0] p,
                                                      input logic neg_p,
                                                      input logic signed [PRW-1:0] q,
                                                      input logic neg_q);
    logic signed [67:0] a;
    logic signed [67:0] b;
    logic signed [67:0] t;
    logic signed [37:0] rr;
    a = neg_p ? -68'(p) : 68'(p);
    b = neg_q ? -68'(q) : 68'(q);
    t = (a + b) <<< 1;
    if (diag) begin
      t = t + (68'sd1 <<< 60);
    end
    t  = t + (68'sd1 <<< 29);
    rr = t[67:30];
    // clamp a non-unit quaternion's entry to [-1, 1]
    if (rr > OneQ30) begin
      rot_entry = RW'(OneQ30);
    end else if (rr < -OneQ30) begin
      rot_entry = RW'(-OneQ30);
    end else begin
      rot_entry = RW'(rr);
    end
  endfunction

  assign rmat_o[0][0] = rot_entry(1'b1, prod_i.yy, 1'b1, prod_i.zz, 1'b1);
  assign rmat_o[0][1] = rot_entry(1'b0, prod_i.xy, 1'b0, prod_i.wz, 1'b1);
  assign rmat_o[0][2] = rot_entry(1'b0, prod_i.xz, 1'b0, prod_i.wy, 1'b0);
  assign rmat_o[1][0] = rot_entry(1'b0, prod_i.xy, 1'b0, prod_i.wz, 1'b0);
  assign rmat_o[1][1] = rot_entry(1'b1, prod_i.xx, 1'b1, prod_i.zz, 1'b1);
  assign rmat_o[1][2] = rot_entry(1'b0, prod_i.yz, 1'b0, prod_i.wx, 1'b1);
  assign rmat_o[2][0] = rot_entry(1'b0, prod_i.xz, 1'b0, prod_i.wy, 1'b1);
  assign rmat_o[2][1] = rot_entry(1'b0, prod_i.yz, 1'b0, prod_i.wx, 1'b0);
  assign rmat_o[2][2] = rot_entry(1'b1, prod_i.xx, 1'b1, prod_i.yy, 1'b1);

endmodule

[rtl/covariance_rotation_scale_propagate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// covariance_rotation_scale_propagate: R*C*R^T with optional scale squared
// Eight-stage pipeline rotating a symmetric 3x3 fixed-point covariance.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o   | action, quat_w/x/y/z, scale, cov_* (6)
//  out     | out_valid_o / out_ready_i | out_* (6), overflow
//
//  One transaction enters per cycle while in_ready_o is high; a result moves
//  through the eight register stages A to H after its input transaction is
//  accepted, and leaves the output register when out_ready_i is high.
//  The last stage is the output register; any empty stage lets the ones
//  behind it advance, so a stall loses and repeats nothing.
//  Reset clears only the stage valid bits; data registers carry no reset.
//
//  Stages: A quaternion products, B rotation entries and s*s,
//  C R x C partial products, D T = C*R^T, E R x T partial products,
//  F sum and round to Q.32, G value x s*s partial products,
//  H round, saturate and register the result.
// ----------------------------------------------------------------------------
module covariance_rotation_scale_propagate
  import crsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic signed [QW-1:0]  quat_w_i,
  input  logic signed [QW-1:0]  quat_x_i,
  input  logic signed [QW-1:0]  quat_y_i,
  input  logic signed [QW-1:0]  quat_z_i,
  input  logic        [SW-1:0]  scale_factor_i,
  input  logic signed [CW-1:0]  cov_xx_i,
  input  logic signed [CW-1:0]  cov_xy_i,
  input  logic signed [CW-1:0]  cov_xz_i,
  input  logic signed [CW-1:0]  cov_yy_i,
  input  logic signed [CW-1:0]  cov_yz_i,
  input  logic signed [CW-1:0]  cov_zz_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [CW-1:0]  out_xx_o,
  output logic signed [CW-1:0]  out_xy_o,
  output logic signed [CW-1:0]  out_xz_o,
  output logic signed [CW-1:0]  out_yy_o,
  output logic signed [CW-1:0]  out_yz_o,
  output logic signed [CW-1:0]  out_zz_o,
  output logic                  overflow_o
);

  localparam int NSTG = 8;
  localparam int TW   = 80;    // T = C*R^T entry, bounded below 2^79
  localparam int AW   = 114;   // full R*C*R^T sum in Q.92
  localparam int VW   = 54;    // result rounded to Q.32
  localparam int PW   = 118;   // value times s*s in Q.64
  localparam int XW   = 86;    // position result rounded to Q.32

  // symmetric index map into the six covariance entries
  localparam int CovPos [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
  localparam int OutRow [NCOV] = '{0, 0, 0, 1, 1, 2};
  localparam int OutCol [NCOV] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic            ovf;
    logic [CW-1:0]   val;
  } sat_t;

  // Saturate to the 48-bit signed range: fits when the top bits all agree.
  function automatic sat_t sat48(input logic signed [XW-1:0] x);
    sat_t r;
    if ((x[XW-1:CW-1] == '0) || (x[XW-1:CW-1] == '1)) begin
      r.ovf = 1'b0;
      r.val = x[CW-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = x[XW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or its successor advances.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: quaternion products
  // --------------------------------------------------------------------------
  quat_prod_t             prod_a_q;
  logic                   act_a_q;
  logic        [SW-1:0]   s_a_q;
  logic signed [CW-1:0]   cov_a_q [NCOV];

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      prod_a_q.xx <= quat_x_i * quat_x_i;
      prod_a_q.yy <= quat_y_i * quat_y_i;
      prod_a_q.zz <= quat_z_i * quat_z_i;
      prod_a_q.xy <= quat_x_i * quat_y_i;
      prod_a_q.xz <= quat_x_i * quat_z_i;
      prod_a_q.yz <= quat_y_i * quat_z_i;
      prod_a_q.wx <= quat_w_i * quat_x_i;
      prod_a_q.wy <= quat_w_i * quat_y_i;
      prod_a_q.wz <= quat_w_i * quat_z_i;
      act_a_q     <= action_i;
      s_a_q       <= scale_factor_i;
      cov_a_q[0]  <= cov_xx_i;
      cov_a_q[1]  <= cov_xy_i;
      cov_a_q[2]  <= cov_xz_i;
      cov_a_q[3]  <= cov_yy_i;
      cov_a_q[4]  <= cov_yz_i;
      cov_a_q[5]  <= cov_zz_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: rotation matrix and scale squared
  // --------------------------------------------------------------------------
  logic signed [RW-1:0]   rmat_d [3][3];
  logic signed [RW-1:0]   r_b_q  [3][3];
  logic        [2*SW-1:0] s2_b_q;
  logic                   act_b_q;
  logic signed [CW-1:0]   cov_b_q [NCOV];

  crsp_quat_rot u_quat_rot (
    .prod_i (prod_a_q),
    .rmat_o (rmat_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[1] && v_q[0]) begin
      r_b_q   <= rmat_d;
      s2_b_q  <= s_a_q * s_a_q;
      act_b_q <= act_a_q;
      cov_b_q <= cov_a_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: R_jl x C_kl, covariance split into signed high and unsigned low
  // --------------------------------------------------------------------------
  logic signed [64:0]     pc_lo_q [3][3][3];
  logic signed [47:0]     pc_hi_q [3][3][3];
  logic signed [RW-1:0]   r_c_q   [3][3];
  logic        [2*SW-1:0] s2_c_q;
  logic                   act_c_q;

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          for (int l = 0; l < 3; l++) begin
            pc_lo_q[k][j][l] <= r_b_q[j][l] *
                                $signed({1'b0, cov_b_q[CovPos[k][l]][31:0]});
            pc_hi_q[k][j][l] <= r_b_q[j][l] * $signed(cov_b_q[CovPos[k][l]][CW-1:32]);
          end
        end
      end
      r_c_q   <= r_b_q;
      s2_c_q  <= s2_b_q;
      act_c_q <= act_b_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: T_kj = sum over l of C_kl * R_jl
  // --------------------------------------------------------------------------
  logic signed [TW-1:0]   t_d_q [3][3];
  logic signed [RW-1:0]   r_d_q [3][3];
  logic        [2*SW-1:0] s2_d_q;
  logic                   act_d_q;

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          t_d_q[k][j] <= (TW'(pc_hi_q[k][j][0]) <<< 32) + TW'(pc_lo_q[k][j][0]) +
                         (TW'(pc_hi_q[k][j][1]) <<< 32) + TW'(pc_lo_q[k][j][1]) +
                         (TW'(pc_hi_q[k][j][2]) <<< 32) + TW'(pc_lo_q[k][j][2]);
        end
      end
      r_d_q   <= r_c_q;
      s2_d_q  <= s2_c_q;
      act_d_q <= act_c_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: R_ik x T_kj, T split into two unsigned words and a signed top
  // --------------------------------------------------------------------------
  logic signed [64:0]     pe_lo_q  [NCOV][3];
  logic signed [64:0]     pe_mid_q [NCOV][3];
  logic signed [47:0]     pe_hi_q  [NCOV][3];
  logic        [2*SW-1:0] s2_e_q;
  logic                   act_e_q;

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      for (int e = 0; e < NCOV; e++) begin
        for (int k = 0; k < 3; k++) begin
          pe_lo_q[e][k]  <= r_d_q[OutRow[e]][k] *
                            $signed({1'b0, t_d_q[k][OutCol[e]][31:0]});
          pe_mid_q[e][k] <= r_d_q[OutRow[e]][k] *
                            $signed({1'b0, t_d_q[k][OutCol[e]][63:32]});
          pe_hi_q[e][k]  <= r_d_q[OutRow[e]][k] *
                            $signed(t_d_q[k][OutCol[e]][TW-1:64]);
        end
      end
      s2_e_q  <= s2_d_q;
      act_e_q <= act_d_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: full sum in Q.92, round half up to Q.32
  // --------------------------------------------------------------------------
  logic signed [AW-1:0]   acc_d [NCOV];
  logic signed [VW-1:0]   v_f_q [NCOV];
  logic        [2*SW-1:0] s2_f_q;
  logic                   act_f_q;

  always_comb begin
    for (int e = 0; e < NCOV; e++) begin
      acc_d[e] = AW'(1) <<< 59;
      for (int k = 0; k < 3; k++) begin
        acc_d[e] = acc_d[e] + (AW'(pe_hi_q[e][k]) <<< 64) +
                   (AW'(pe_mid_q[e][k]) <<< 32) + AW'(pe_lo_q[e][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      for (int e = 0; e < NCOV; e++) begin
        v_f_q[e] <= acc_d[e][AW-1:60];
      end
      s2_f_q  <= s2_e_q;
      act_f_q <= act_e_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: value x s*s partial products (used only in position mode)
  // --------------------------------------------------------------------------
  logic        [63:0]     pg_ll_q [NCOV];
  logic        [63:0]     pg_lh_q [NCOV];
  logic signed [54:0]     pg_hl_q [NCOV];
  logic signed [54:0]     pg_hh_q [NCOV];
  logic signed [VW-1:0]   v_g_q   [NCOV];
  logic                   act_g_q;

  always_ff @(posedge clk_i) begin
    if (en[6] && v_q[5]) begin
      for (int e = 0; e < NCOV; e++) begin
        pg_ll_q[e] <= v_f_q[e][31:0] * s2_f_q[31:0];
        pg_lh_q[e] <= v_f_q[e][31:0] * s2_f_q[63:32];
        pg_hl_q[e] <= $signed(v_f_q[e][VW-1:32]) * $signed({1'b0, s2_f_q[31:0]});
        pg_hh_q[e] <= $signed(v_f_q[e][VW-1:32]) * $signed({1'b0, s2_f_q[63:32]});
      end
      v_g_q   <= v_f_q;
      act_g_q <= act_f_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: combine, round to Q.32, saturate and hold for the consumer
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]   p_d   [NCOV];
  logic signed [XW-1:0]   x_d   [NCOV];
  sat_t                   sat_d [NCOV];
  logic        [CW-1:0]   out_q [NCOV];
  logic                   ovf_q;

  always_comb begin
    for (int e = 0; e < NCOV; e++) begin
      p_d[e] = (PW'(pg_hh_q[e]) <<< 64) + (PW'(pg_hl_q[e]) <<< 32) +
               (PW'({1'b0, pg_lh_q[e]}) <<< 32) + PW'({1'b0, pg_ll_q[e]}) +
               (PW'(1) <<< 31);
      x_d[e]   = act_g_q ? p_d[e][PW-1:32] : XW'(v_g_q[e]);
      sat_d[e] = sat48(x_d[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7] && v_q[6]) begin
      for (int e = 0; e < NCOV; e++) begin
        out_q[e] <= sat_d[e].val;
      end
      ovf_q <= sat_d[0].ovf | sat_d[1].ovf | sat_d[2].ovf |
               sat_d[3].ovf | sat_d[4].ovf | sat_d[5].ovf;
    end
  end

  assign out_xx_o   = out_q[0];
  assign out_xy_o   = out_q[1];
  assign out_xz_o   = out_q[2];
  assign out_yy_o   = out_q[3];
  assign out_yz_o   = out_q[4];
  assign out_zz_o   = out_q[5];
  assign overflow_o = ovf_q;

`ifndef ASSERT_OFF
  localparam logic signed [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [RW-1:0] OneR = RW'(1) <<< 30;

  // an empty first stage always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_ready_o)
    else $error("input stalled with an empty first stage");

  // a flagged result carries at least one entry at a saturation bound
  a_ovf_has_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (out_xx_o == MaxV || out_xx_o == MinV || out_xy_o == MaxV || out_xy_o == MinV ||
       out_xz_o == MaxV || out_xz_o == MinV || out_yy_o == MaxV || out_yy_o == MinV ||
       out_yz_o == MaxV || out_yz_o == MinV || out_zz_o == MaxV || out_zz_o == MinV))
    else $error("overflow flagged without a saturated entry");

  // rotation entries [0][0] and [1][2] stay clamped to [-1, 1]
  a_rot_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (r_b_q[0][0] <= OneR && r_b_q[0][0] >= -OneR &&
                r_b_q[1][2] <= OneR && r_b_q[1][2] >= -OneR))
    else $error("rotation entry outside the unit range");
`endif

endmodule
